// ===== rtl/core/trd_pkg.sv =====
// Package for the touch report decoder core.
// Holds the coordinate widths, the report job type and the byte position codes.
// No dependencies.
package trd_pkg;

	localparam int COORD_BITS = 12;
	localparam int LOW_BITS = 7;
	localparam int HI_BITS = ((COORD_BITS - LOW_BITS) > 8) ? 8 : (COORD_BITS - LOW_BITS);
	localparam int SIZE_BITS = 12;
	localparam int PIX_BITS = 12;
	localparam int PROD_BITS = COORD_BITS + SIZE_BITS;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = QPTR_BITS + 1;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam logic CFG_IDX_WIDTH = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam logic [SIZE_BITS-1:0] WIDTH_RESET = 12'd800;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 12'd480;

	typedef enum logic [2:0] {
		POS_HEADER = 3'd0,
		POS_X_LO   = 3'd1,
		POS_X_HI   = 3'd2,
		POS_Y_LO   = 3'd3,
		POS_Y_HI   = 3'd4
	} pos_t;

	// One classified report waiting for scaling.
	typedef struct packed {
		logic                  bad;
		logic                  pen;
		logic [COORD_BITS-1:0] x_raw;
		logic [COORD_BITS-1:0] y_raw;
	} trd_job_t;

	function automatic logic [COORD_BITS-1:0] make_raw(input logic [HI_BITS-1:0] hi,
		input logic [LOW_BITS-1:0] lo);
		make_raw = COORD_BITS'({hi, lo});
	endfunction

endpackage

// ===== rtl/core/trd_front.sv =====
// Front end of the touch report decoder: byte framing and report assembly.
// Depends on trd_pkg.
module trd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	input  logic [7:0]           rx_byte,
	input  logic                 q_full,
	output logic                 rx_stall,
	output logic                 push,
	output trd_pkg::trd_job_t    push_job
);
	import trd_pkg::*;

	pos_t                pos_q, pos_d;
	logic                fire;
	logic                pen_q;
	logic [LOW_BITS-1:0] x_lo_q;
	logic [HI_BITS-1:0]  x_hi_q;
	logic [LOW_BITS-1:0] y_lo_q;

	assign rx_stall = q_full;
	assign fire = rx_valid & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HEADER;
		end else begin
			pos_q <= pos_d;
		end
	end

	always_comb begin
		pos_d = pos_q;
		push = 1'b0;
		push_job = '0;
		unique case (pos_q)
			POS_X_LO: if (fire) pos_d = POS_X_HI;
			POS_X_HI: if (fire) pos_d = POS_Y_LO;
			POS_Y_LO: if (fire) pos_d = POS_Y_HI;
			POS_Y_HI: if (fire) begin
				pos_d = POS_HEADER;
				push = 1'b1;
				push_job.pen = pen_q;
				push_job.x_raw = make_raw(x_hi_q, x_lo_q);
				push_job.y_raw = make_raw(rx_byte[HI_BITS-1:0], y_lo_q);
			end
			default: if (fire) begin
				// header expected; a byte without the sync bit is reported at once
				if (!rx_byte[7]) begin
					pos_d = POS_HEADER;
					push = 1'b1;
					push_job.bad = 1'b1;
				end else begin
					pos_d = POS_X_LO;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (pos_q)
				POS_X_LO: x_lo_q <= rx_byte[LOW_BITS-1:0];
				POS_X_HI: x_hi_q <= rx_byte[HI_BITS-1:0];
				POS_Y_LO: y_lo_q <= rx_byte[LOW_BITS-1:0];
				POS_Y_HI: ;
				default:  pen_q <= rx_byte[0];
			endcase
		end
	end

endmodule

// ===== rtl/core/trd_queue.sv =====
// Short queue of assembled report jobs between front and back ends.
// Depends on trd_pkg.
module trd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trd_pkg::trd_job_t    push_job,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output trd_pkg::trd_job_t    head_job
);
	import trd_pkg::*;

	trd_job_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;

	assign full = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			priority if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== rtl/core/trd_back.sv =====
// Back end of the touch report decoder: coordinate scaling and output register.
// Depends on trd_pkg.
module trd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  trd_pkg::trd_job_t            head_job,
	input  logic [trd_pkg::SIZE_BITS-1:0] width,
	input  logic [trd_pkg::SIZE_BITS-1:0] height,
	input  logic                         report_stall,
	output logic                         pop,
	output logic                         report_valid,
	output logic                         bad_header,
	output logic                         pen_down,
	output logic [trd_pkg::PIX_BITS-1:0] x_pixel,
	output logic [trd_pkg::PIX_BITS-1:0] y_pixel
);
	import trd_pkg::*;

	logic                 valid_q;
	logic                 bad_q, pen_q;
	logic [PIX_BITS-1:0]  x_q, y_q;
	logic [PROD_BITS-1:0] x_prod, y_prod;

	// load the output register whenever a job is waiting and the register is empty or being drained
	assign pop = ~q_empty & (~valid_q | ~report_stall);

	assign x_prod = PROD_BITS'(head_job.x_raw) * PROD_BITS'(width);
	assign y_prod = PROD_BITS'(head_job.y_raw) * PROD_BITS'(height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!report_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bad_q <= head_job.bad;
			pen_q <= head_job.pen;
			x_q <= x_prod[COORD_BITS +: PIX_BITS];
			y_q <= y_prod[COORD_BITS +: PIX_BITS];
		end
	end

	assign report_valid = valid_q;
	assign bad_header = bad_q;
	assign pen_down = pen_q;
	assign x_pixel = x_q;
	assign y_pixel = y_q;

endmodule

// ===== rtl/core/touch_report_decoder_core.sv =====
// Top level of the touch report decoder core: config registers and block wiring.
// Depends on trd_pkg, trd_front, trd_queue and trd_back.
//
// Usage:
//   rx_byte / rx_valid / rx_stall carry bytes from a UART receiver. A byte
//   transfers at a rising edge with rx_valid high and rx_stall low.
//   A report consists of a header byte (bit 7 set, bit 0 = pen down) and four
//   data bytes: X low 7 bits, X high part, Y low 7 bits, Y high part.
//   A header byte without bit 7 yields one report with bad_header set and
//   pen_down, x_pixel, y_pixel zero; the core keeps hunting for a header.
//   Good reports carry raw * screen_size >> 12 for each axis.
//   report_valid / report_stall carry results; a result transfers at an edge
//   with report_valid high and report_stall low. A stalled result holds.
// Data flow:
//   A completed report passes the job queue, then the output register. Bytes
//   are taken one per cycle while rx_stall is low; the front end decodes into
//   a four-entry job queue, and the back end scales one job per cycle unless it
//   is stalled, through two 12x12 multipliers into the output register.
//   When report_stall is held, the queue fills and rx_stall rises only once
//   four further reports are waiting; bytes that finish no report are still
//   taken while there is room.
// Reset:
//   arst_n clears framing to header hunt, empties the queue and drops
//   report_valid. screen_width resets to 800, screen_height to 480.
// Config (APB, pready always high): 0x0 screen_width, 0x4 screen_height.
module touch_report_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [trd_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [trd_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [trd_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                              pready,
	input  logic [7:0]                        rx_byte,
	input  logic                              rx_valid,
	output logic                              rx_stall,
	output logic                              bad_header,
	output logic                              pen_down,
	output logic [trd_pkg::PIX_BITS-1:0]      x_pixel,
	output logic [trd_pkg::PIX_BITS-1:0]      y_pixel,
	output logic                              report_valid,
	input  logic                              report_stall
);
	import trd_pkg::*;

	logic [SIZE_BITS-1:0] width_q, height_q;
	logic                 cfg_wr;
	logic                 cfg_idx;
	logic                 q_full, q_empty, push, pop;
	trd_job_t             push_job, head_job;

	// Config port: decode on the register slot bit only, low address bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				CFG_IDX_WIDTH:  width_q <= pwdata[SIZE_BITS-1:0];
				CFG_IDX_HEIGHT: height_q <= pwdata[SIZE_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			CFG_IDX_WIDTH:  prdata = CFG_DATA_BITS'(width_q);
			CFG_IDX_HEIGHT: prdata = CFG_DATA_BITS'(height_q);
		endcase
	end

	// Front end: frame bytes into report jobs
	trd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.rx_stall (rx_stall),
		.push     (push),
		.push_job (push_job)
	);

	// Decouple framing from the scaling/output side
	trd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head_job (head_job)
	);

	// Back end: scale and present reports
	trd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head_job     (head_job),
		.width        (width_q),
		.height       (height_q),
		.report_stall (report_stall),
		.pop          (pop),
		.report_valid (report_valid),
		.bad_header   (bad_header),
		.pen_down     (pen_down),
		.x_pixel      (x_pixel),
		.y_pixel      (y_pixel)
	);

endmodule

// ===== rtl/core/trd_checker.sv =====
// Port-level checker for the touch report decoder core, with its bind.
// Depends on trd_pkg and touch_report_decoder_core.
module trd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rx_stall,
	input logic                         report_valid,
	input logic                         report_stall,
	input logic                         bad_header,
	input logic                         pen_down,
	input logic [trd_pkg::PIX_BITS-1:0] x_pixel,
	input logic [trd_pkg::PIX_BITS-1:0] y_pixel
);
	import trd_pkg::*;

	// A bad header report carries no pen state and no coordinates
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && bad_header |-> !pen_down && x_pixel == '0 && y_pixel == '0)
		else $error("bad header report with nonzero fields");

	// Scaled coordinates never reach full scale
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> x_pixel != '1 && y_pixel != '1)
		else $error("scaled coordinate out of range");

	// Input backpressure only follows a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!report_valid |-> !rx_stall)
		else $error("rx stalled while output register empty");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_stall |=> report_valid && $stable(bad_header)
		&& $stable(pen_down) && $stable(x_pixel) && $stable(y_pixel))
		else $error("stalled report changed");

endmodule

bind touch_report_decoder_core trd_checker u_trd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_stall     (rx_stall),
	.report_valid (report_valid),
	.report_stall (report_stall),
	.bad_header   (bad_header),
	.pen_down     (pen_down),
	.x_pixel      (x_pixel),
	.y_pixel      (y_pixel)
);
